/* src/prts_pkg.sv */
// prts_pkg: shared types and constants for the primitive-to-restart-strip block.
// Depends on nothing; imported by every module in src.
package prts_pkg;

   localparam int INDEX_BITS  = 16;
   localparam int JOB_SLOTS   = 4;
   localparam int SLOT_BITS   = $clog2(JOB_SLOTS);
   localparam int COUNT_BITS  = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int PADDR_BITS  = 3;
   localparam int PDATA_BITS  = 32;

   localparam logic [INDEX_BITS-1:0] RESTART_VALUE = '1;

   localparam logic [PADDR_BITS-3:0] REG_TOPOLOGY = '0;

   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;
   localparam logic [1:0] PHASE_3 = 2'd3;

   typedef enum logic [1:0] {
      TOPO_TRIANGLE = 2'd0,
      TOPO_FAN      = 2'd1,
      TOPO_QUAD     = 2'd2,
      TOPO_DISCARD  = 2'd3
   } topology_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] index_value;
      logic                  final_index;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] strip_index;
      logic                  restart_marker;
      logic                  run_last;
   } rsp_type;

   // one input item's worth of output: indices, then an optional restart
   typedef struct packed {
      logic [JOB_SLOTS-1:0][INDEX_BITS-1:0] idx;
      logic [COUNT_BITS-1:0]                count;
      logic                                 restart;
      logic [COUNT_BITS-1:0]                length;
   } job_type;

endpackage

/* src/prts_front.sv */
// prts_front: accepts index transfers, tracks the primitive pattern and
// builds at most one output job per item. Depends on prts_pkg.
module prts_front import prts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  topology_type mode,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_payload,
   input  logic         queue_full,
   output logic         push_valid,
   output job_type      push_job
);

   logic [2:0][INDEX_BITS-1:0] held_ff, held_in;
   logic [INDEX_BITS-1:0]      anchor_ff, anchor_in;
   logic [1:0]                 phase_ff, phase_in;
   logic                       warm_ff, warm_in;
   logic                       accept;
   logic [1:0]                 ph_tri;
   logic [INDEX_BITS-1:0]      x;
   logic                       last;
   job_type                    job;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign x         = req_payload.index_value;
   assign last      = req_payload.final_index;
   assign ph_tri    = (phase_ff == PHASE_3) ? PHASE_0 : phase_ff;

   always_comb begin
      held_in     = held_ff;
      anchor_in   = anchor_ff;
      phase_in    = phase_ff;
      warm_in     = warm_ff;
      job.idx     = '0;
      job.count   = '0;
      job.restart = 1'b0;
      case (mode)
         TOPO_TRIANGLE: begin
            if (ph_tri != PHASE_2) begin
               held_in[ph_tri] = x;
               phase_in        = ph_tri + 2'd1;
            end else begin
               job.idx[0]  = held_ff[0];
               job.idx[1]  = held_ff[1];
               job.idx[2]  = x;
               job.count   = COUNT_BITS'(3);
               job.restart = 1'b1;
               phase_in    = PHASE_0;
            end
         end
         TOPO_FAN: begin
            if (!warm_ff) begin
               anchor_in = x;
               warm_in   = 1'b1;
               phase_in  = PHASE_3;
            end else begin
               case (phase_ff)
                  PHASE_3: begin
                     held_in[0] = x;
                     phase_in   = PHASE_0;
                  end
                  PHASE_0: begin
                     job.idx[0]  = held_ff[0];
                     job.idx[1]  = x;
                     job.idx[2]  = anchor_ff;
                     job.count   = COUNT_BITS'(3);
                     job.restart = last;
                     phase_in    = PHASE_1;
                  end
                  PHASE_1: begin
                     job.idx[0]  = x;
                     job.count   = COUNT_BITS'(1);
                     job.restart = last;
                     phase_in    = PHASE_2;
                  end
                  default: begin
                     job.idx[0]  = x;
                     job.count   = COUNT_BITS'(1);
                     job.restart = 1'b1;
                     held_in[0]  = x;
                     phase_in    = PHASE_0;
                  end
               endcase
            end
         end
         TOPO_QUAD: begin
            if (phase_ff != PHASE_3) begin
               held_in[phase_ff] = x;
               phase_in          = phase_ff + 2'd1;
               if (phase_ff == PHASE_2 && last) begin
                  job.idx[0]  = held_ff[0];
                  job.idx[1]  = held_ff[1];
                  job.idx[2]  = x;
                  job.count   = COUNT_BITS'(3);
                  job.restart = 1'b1;
               end
            end else begin
               job.idx[0]  = held_ff[1];
               job.idx[1]  = held_ff[2];
               job.idx[2]  = held_ff[0];
               job.idx[3]  = x;
               job.count   = COUNT_BITS'(4);
               job.restart = 1'b1;
               phase_in    = PHASE_0;
            end
         end
         default: begin
         end
      endcase
      if (last) begin
         phase_in = PHASE_0;
         warm_in  = 1'b0;
      end
      job.length = job.count + COUNT_BITS'(job.restart);
   end

   assign push_valid = accept && (job.length != '0);
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_0;
         warm_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         warm_ff  <= warm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff   <= held_in;
         anchor_ff <= anchor_in;
      end
   end

endmodule

/* src/prts_queue.sv */
// prts_queue: short job FIFO between front and back ends.
// Depends on prts_pkg.
module prts_queue import prts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    queue_full,
   output logic    pop_valid,
   output job_type pop_job,
   input  logic    pop
);

   job_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign queue_full = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* src/prts_back.sv */
// prts_back: holds the current job and serialises it onto the result
// channel, one transfer per cycle while the receiver is ready. Depends on prts_pkg.
module prts_back import prts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   input  job_type pop_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   job_type               job_ff, job_in;
   logic                  busy_ff, busy_in;
   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   logic                  take, done, load;

   assign rsp_valid = busy_ff;
   assign take      = rsp_valid && rsp_ready;
   assign done      = take && rsp_payload.run_last;
   assign load      = (!busy_ff || done) && pop_valid;
   assign pop       = load;

   always_comb begin
      if (pos_ff < job_ff.count) begin
         rsp_payload.strip_index    = job_ff.idx[pos_ff[SLOT_BITS-1:0]];
         rsp_payload.restart_marker = 1'b0;
      end else begin
         rsp_payload.strip_index    = RESTART_VALUE;
         rsp_payload.restart_marker = 1'b1;
      end
      rsp_payload.run_last = (pos_ff == job_ff.length - COUNT_BITS'(1));
   end

   always_comb begin
      job_in  = job_ff;
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (load) begin
         job_in  = pop_job;
         busy_in = 1'b1;
         pos_in  = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (take) begin
         pos_in = pos_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   a_pos_in_job: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff < job_ff.length))
      else $error("result position beyond job length");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(pos_ff)))
      else $error("stalled result moved");

   a_pop_only_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (pop_valid && (!busy_ff || done)))
      else $error("job popped while current job unfinished");

endmodule

/* src/primitive_to_restart_strip_core.sv */
// primitive_to_restart_strip_core: top level with the topology register and
// front, queue and back ends. Depends on prts_pkg, prts_front, prts_queue, prts_back.
//
// Usage:
//  - req channel: one vertex index per transfer, final_index on the last of
//    a batch. Items are taken one per cycle while the job queue has room.
//  - rsp channel: triangle strip indices and restart markers, one transfer
//    per cycle; run_last flags the last result caused by an input item.
//    Items that complete no primitive give no results.
//  - csr port: register 0 (byte address 0) holds topology_mode, 0 triangle
//    list, 1 fan, 2 quad list, 3 discard. Write only while idle.
// At the earliest, the first result of an item transfers once the item has been
// written into the job queue and then loaded into the result stage.
// Throughput: one input transfer per cycle while the job queue has room; the result
// port moves one result per cycle while the receiver is ready, and an item with
// results has 1 to 5 of them; a four-entry job queue decouples the two sides.
// Reset clears the pattern phase, the queue and the topology register. When the
// receiver stalls the current result holds; items keep being taken until the
// queue fills, then req_ready drops.
module primitive_to_restart_strip_core import prts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [PADDR_BITS-1:0] csr_paddr,
   input  logic [PDATA_BITS-1:0] csr_pwdata,
   output logic [PDATA_BITS-1:0] csr_prdata,
   output logic                  csr_pready
);

   topology_type mode_ff, mode_in;
   logic         reg_hit;
   logic         queue_full, push_valid, pop_valid, pop;
   job_type      push_job, pop_job;

   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[PADDR_BITS-1:2] == REG_TOPOLOGY);

   always_comb begin
      mode_in = mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit) begin
         mode_in = topology_type'(csr_pwdata[1:0]);
      end
      csr_prdata = reg_hit ? {{(PDATA_BITS-2){1'b0}}, mode_ff} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= TOPO_TRIANGLE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   prts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .mode        (mode_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   prts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .queue_full (queue_full),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   prts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* tb/sv/tb_primitive_to_restart_strip_core.sv */
// Testbench for primitive_to_restart_strip_core: drives vertex index batches in
// every topology mode and checks each strip transfer against an in-bench model.
// Depends on prts_pkg and the core RTL; self-contained otherwise.
`timescale 1ns / 1ps

module tb_primitive_to_restart_strip_core;
   import prts_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [PADDR_BITS-1:0] csr_paddr = '0;
   logic [PDATA_BITS-1:0] csr_pwdata = '0;
   logic [PDATA_BITS-1:0] csr_prdata;
   logic                  csr_pready;

   primitive_to_restart_strip_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // strip model state
   topology_type          topo_mode = TOPO_TRIANGLE;
   logic [INDEX_BITS-1:0] held_idx [3];
   logic [INDEX_BITS-1:0] anchor_idx;
   logic [1:0]            group_phase = PHASE_0;
   logic                  anchor_taken = 1'b0;

   req_type index_backlog [$];
   rsp_type expected_strip [$];

   int sender_gap_pct = 0;
   int receiver_stall_pct = 0;
   int hold_asked = 0;
   int hold_given = 0;
   int hold_left = 0;
   int index_count = 0;
   int strip_count = 0;
   int strip_errors = 0;
   int csr_errors = 0;

   function automatic rsp_type strip_entry(input logic [INDEX_BITS-1:0] v, input logic marker);
      rsp_type e;
      e.strip_index    = v;
      e.restart_marker = marker;
      e.run_last       = 1'b0;
      return e;
   endfunction

   task automatic predict_strip(input req_type item);
      rsp_type               burst [5];
      int                    n;
      logic [1:0]            ph;
      logic [INDEX_BITS-1:0] v;
      n  = 0;
      ph = group_phase;
      v  = item.index_value;
      case (topo_mode)
         TOPO_TRIANGLE: begin
            if (ph == PHASE_3) ph = PHASE_0;
            if (ph != PHASE_2) begin
               held_idx[ph] = v;
               group_phase  = ph + 2'd1;
            end else begin
               burst[0] = strip_entry(held_idx[0], 1'b0);
               burst[1] = strip_entry(held_idx[1], 1'b0);
               burst[2] = strip_entry(v, 1'b0);
               burst[3] = strip_entry(RESTART_VALUE, 1'b1);
               n = 4;
               group_phase = PHASE_0;
            end
         end
         TOPO_FAN: begin
            if (!anchor_taken) begin
               anchor_idx   = v;
               anchor_taken = 1'b1;
               group_phase  = PHASE_3;
            end else begin
               case (ph)
                  PHASE_3: begin
                     held_idx[0] = v;
                     group_phase = PHASE_0;
                  end
                  PHASE_0: begin
                     burst[0] = strip_entry(held_idx[0], 1'b0);
                     burst[1] = strip_entry(v, 1'b0);
                     burst[2] = strip_entry(anchor_idx, 1'b0);
                     n = 3;
                     if (item.final_index) begin
                        burst[3] = strip_entry(RESTART_VALUE, 1'b1);
                        n = 4;
                     end
                     group_phase = PHASE_1;
                  end
                  PHASE_1: begin
                     burst[0] = strip_entry(v, 1'b0);
                     n = 1;
                     if (item.final_index) begin
                        burst[1] = strip_entry(RESTART_VALUE, 1'b1);
                        n = 2;
                     end
                     group_phase = PHASE_2;
                  end
                  default: begin
                     burst[0] = strip_entry(v, 1'b0);
                     burst[1] = strip_entry(RESTART_VALUE, 1'b1);
                     n = 2;
                     held_idx[0] = v;
                     group_phase = PHASE_0;
                  end
               endcase
            end
         end
         TOPO_QUAD: begin
            if (ph != PHASE_3) begin
               held_idx[ph] = v;
               group_phase  = ph + 2'd1;
               if (ph == PHASE_2 && item.final_index) begin
                  burst[0] = strip_entry(held_idx[0], 1'b0);
                  burst[1] = strip_entry(held_idx[1], 1'b0);
                  burst[2] = strip_entry(v, 1'b0);
                  burst[3] = strip_entry(RESTART_VALUE, 1'b1);
                  n = 4;
               end
            end else begin
               burst[0] = strip_entry(held_idx[1], 1'b0);
               burst[1] = strip_entry(held_idx[2], 1'b0);
               burst[2] = strip_entry(held_idx[0], 1'b0);
               burst[3] = strip_entry(v, 1'b0);
               burst[4] = strip_entry(RESTART_VALUE, 1'b1);
               n = 5;
               group_phase = PHASE_0;
            end
         end
         default: ;
      endcase
      if (item.final_index) begin
         group_phase  = PHASE_0;
         anchor_taken = 1'b0;
      end
      if (n > 0) burst[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) expected_strip = {expected_strip, burst[i]};
   endtask

   // index driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_strip(req_payload);
            index_count++;
         end
         if (req_valid && !req_ready) begin
            // hold until transfer
         end else if (index_backlog.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
            req_payload <= index_backlog.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver, with an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_asked != hold_given) begin
         hold_left  <= 80;
         hold_given <= hold_given + 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // strip monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         strip_count++;
         if (expected_strip.size() == 0) begin
            $display("%0t: unexpected strip transfer idx=%h restart=%b last=%b", $time,
                     rsp_payload.strip_index, rsp_payload.restart_marker, rsp_payload.run_last);
            strip_errors++;
         end else begin
            want = expected_strip.pop_front();
            if (rsp_payload.strip_index !== want.strip_index ||
                rsp_payload.restart_marker !== want.restart_marker ||
                rsp_payload.run_last !== want.run_last) begin
               $display({"%0t: strip mismatch: expected idx=%h restart=%b last=%b, ",
                         "got idx=%h restart=%b last=%b"},
                        $time, want.strip_index, want.restart_marker, want.run_last,
                        rsp_payload.strip_index, rsp_payload.restart_marker, rsp_payload.run_last);
               strip_errors++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (index_backlog.size() != 0 || req_valid || expected_strip.size() != 0)
         @(posedge clock);
      // zero-result items may still be in flight
      repeat (8) @(posedge clock);
   endtask

   task automatic write_topology(input topology_type mode);
      logic [PDATA_BITS-1:0] readback;
      wait_drained();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_TOPOLOGY, 2'b00};
      csr_pwdata  <= PDATA_BITS'(mode);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      topo_mode = mode;
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== PDATA_BITS'(mode)) begin
         $display("%0t: topology readback mismatch: expected %h, got %h", $time,
                  PDATA_BITS'(mode), readback);
         csr_errors++;
      end
   endtask

   function automatic void offer(input logic [INDEX_BITS-1:0] v, input logic last);
      req_type item;
      item.index_value = v;
      item.final_index = last;
      index_backlog = {index_backlog, item};
   endfunction

   // one batch, mostly whole primitives, sometimes cut short
   function automatic int queue_batch(input topology_type mode);
      int len;
      int r;
      r = $urandom_range(99);
      if (r < 75) begin
         case (mode)
            TOPO_TRIANGLE: len = 3 * $urandom_range(1, 4);
            TOPO_QUAD:     len = 4 * $urandom_range(0, 3) + ($urandom_range(1) ? 3 : 4);
            default:       len = $urandom_range(3, 14);
         endcase
      end else begin
         len = $urandom_range(1, 10);
      end
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(15);
         offer((r == 0) ? '0 : (r == 1) ? '1 : INDEX_BITS'($urandom_range(65535)),
               i == len - 1);
      end
      return len;
   endfunction

   task automatic run_phase(input topology_type mode, input int gap_pct, input int stall_pct,
                            input bit hold_off, input bit pause_mid);
      int queued;
      bit paused;
      queued = 0;
      paused = 0;
      write_topology(mode);
      sender_gap_pct     = gap_pct;
      receiver_stall_pct = stall_pct;
      if (hold_off) hold_asked++;
      while (queued < 16) begin
         if (pause_mid && !paused && queued >= 8) begin
            wait_drained();
            paused = 1;
         end
         queued += queue_batch(mode);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // triangle list: extremes, then a dropped partial triangle
      write_topology(TOPO_TRIANGLE);
      offer(16'h0000, 1'b0);
      offer(16'hFFFF, 1'b0);
      offer(16'h1234, 1'b1);
      offer(16'h0001, 1'b1);
      // quad plus leftover triangle, then a dropped single index
      write_topology(TOPO_QUAD);
      offer(16'hAAAA, 1'b0);
      offer(16'h5555, 1'b0);
      offer(16'h0F0F, 1'b0);
      offer(16'hF0F0, 1'b0);
      offer(16'h0102, 1'b0);
      offer(16'h0304, 1'b0);
      offer(16'h0506, 1'b1);
      offer(16'h0007, 1'b1);
      // fans: full groups, end inside a group, too short
      write_topology(TOPO_FAN);
      offer(16'h0100, 1'b0);
      offer(16'h0101, 1'b0);
      offer(16'h0102, 1'b0);
      offer(16'h0103, 1'b0);
      offer(16'h0104, 1'b0);
      offer(16'h0105, 1'b1);
      offer(16'h0200, 1'b0);
      offer(16'h0201, 1'b0);
      offer(16'h0202, 1'b0);
      offer(16'h0203, 1'b1);
      offer(16'h0210, 1'b0);
      offer(16'h0211, 1'b1);
      // discard mode
      write_topology(TOPO_DISCARD);
      offer(16'h7777, 1'b1);
      // mode change mid-batch: fan anchor leaves phase three, read as zero in triangles
      write_topology(TOPO_FAN);
      offer(16'h0300, 1'b0);
      write_topology(TOPO_TRIANGLE);
      offer(16'h0301, 1'b0);
      offer(16'h0302, 1'b0);
      offer(16'h0303, 1'b1);

      run_phase(TOPO_FAN,      0,  0,  0, 0);
      run_phase(TOPO_QUAD,     47, 0,  0, 0);
      run_phase(TOPO_TRIANGLE, 0,  47, 0, 0);
      run_phase(TOPO_FAN,      33, 33, 0, 0);
      run_phase(TOPO_QUAD,     0,  0,  1, 0);
      run_phase(TOPO_FAN,      0,  0,  1, 0);
      run_phase(TOPO_TRIANGLE, 33, 33, 0, 1);
      run_phase(topology_type'($urandom_range(2)), 33, 33, 0, 0);

      for (int c = 0; c < 20000 &&
           (index_backlog.size() != 0 || req_valid || expected_strip.size() != 0); c++)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (expected_strip.size() != 0)
         $display("%0t: %0d expected strip transfers never arrived", $time, expected_strip.size());

      $display("Run covered %0d index transfers and %0d strip transfers", index_count, strip_count);
      $display("over triangle, fan, quad and discard modes with sender gaps and receiver stalls");
      if (strip_errors == 0 && csr_errors == 0 && expected_strip.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
